// ===== hw/rtl/hbd_pkg.sv =====
package hbd_pkg;

  // Default table size and longest code the accumulator can hold.
  localparam int SYMBOL_COUNT_DEF = 128;
  localparam int MAX_CODE_LEN_DEF = 32;

  // Fixed field widths of the stream words.
  localparam int SYM_W  = 7;
  localparam int CODE_W = 32;
  localparam int LEN_W  = 6;
  localparam int STAT_W = 2;

  // Command codes.
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_SYMBOL   = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd1;
  localparam logic [STAT_W-1:0] ST_LEFTOVER = 2'd2;

  // One code table entry as it sits in the table memory.
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } entry_t;

endpackage

// ===== hw/rtl/huffman_bit_decoder.sv =====
// Flow: a decode word starts a table scan that reads one entry per cycle, lowest symbol first,
// from the table memory and compares each read entry with the held bits; a match, an overflow
// or a leftover becomes a result word once the output register is free, and a scan with no
// result returns to idle. A load word is taken every cycle while idle; a decode word is not
// taken until the previous scan and any result it gave have left for the output register.
// Reset: synchronous, active high; clears the accumulator, the entry valid bits and the output valid flag.
module huffman_bit_decoder #(
  parameter int SYMBOL_COUNT = hbd_pkg::SYMBOL_COUNT_DEF,
  parameter int MAX_CODE_LEN = hbd_pkg::MAX_CODE_LEN_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       command,
  input  logic [hbd_pkg::SYM_W-1:0]  entry_symbol,
  input  logic [hbd_pkg::CODE_W-1:0] entry_code,
  input  logic [hbd_pkg::LEN_W-1:0]  entry_length,
  input  logic                       code_bit,
  input  logic                       message_end,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [hbd_pkg::SYM_W-1:0]  symbol,
  output logic [hbd_pkg::STAT_W-1:0] status
);
  import hbd_pkg::*;

  // Table index width, and a width wide enough for both an index and a symbol.
  localparam int IDX_W = $clog2(SYMBOL_COUNT);
  localparam int PAD_W = (IDX_W > SYM_W) ? IDX_W : SYM_W;
  // The accumulator holds at most MAX_CODE_LEN bits before it is cleared.
  localparam int ACC_W = MAX_CODE_LEN;
  localparam int CMP_W = (ACC_W > CODE_W) ? ACC_W : CODE_W;
  localparam int BH_W  = $clog2(MAX_CODE_LEN + 1);
  localparam int LC_W  = (BH_W > LEN_W) ? BH_W : LEN_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SYMBOL_COUNT - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT
  } state_t;

  state_t state;

  // The code table lives in one synchronous memory. The length part of an entry
  // has no reset value, so each entry carries a valid bit in flip-flops; an
  // entry that was never loaded reads as absent.
  entry_t                  table_mem [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] entry_valid;

  // Accumulated stream bits, their count, and a mask that covers exactly the held
  // bits. Bits above the count are always zero, so masking the stored code is enough.
  logic [ACC_W-1:0] acc;
  logic [CMP_W-1:0] hold_mask;
  logic [BH_W-1:0]  bits_held;
  logic             last_bit;

  // Scan address side and read data side of the memory pipeline.
  logic             issuing;
  logic [IDX_W-1:0] issue_idx;
  entry_t           rd_entry;
  logic             rd_vld;
  logic             rd_ok;
  logic             rd_end;
  logic [IDX_W-1:0] rd_sym;

  // Result waiting for the output register.
  logic [SYM_W-1:0]  res_symbol;
  logic [STAT_W-1:0] res_status;

  logic             accept;
  logic             load_we;
  logic [IDX_W-1:0] load_idx;
  logic             len_hit;
  logic             code_hit;
  logic             hit;
  logic [PAD_W-1:0] sym_wide;
  logic             emit_go;

  // Inputs are taken only between scans, so a load never races a table read.
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign load_we  = accept && (command == CMD_LOAD) &&
                    ({25'd0, entry_symbol} < 32'(SYMBOL_COUNT));
  assign load_idx = IDX_W'({25'd0, entry_symbol});

  // A stored length equal to the held count implies a nonzero length, since at
  // least one bit is held during every scan.
  assign len_hit  = (LC_W'(rd_entry.len) == LC_W'(bits_held));
  assign code_hit = ((CMP_W'(rd_entry.code) & hold_mask) == CMP_W'(acc));
  assign hit      = rd_vld && rd_ok && len_hit && code_hit;
  assign sym_wide = PAD_W'(rd_sym);

  // The pending result moves to the output register once that register is free.
  assign emit_go  = (state == S_EMIT) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (load_we) begin
      table_mem[load_idx] <= '{code: entry_code, len: entry_length};
    end
    if (issuing) begin
      rd_entry <= table_mem[issue_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (load_we) begin
      entry_valid[load_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      acc       <= '0;
      hold_mask <= '0;
      bits_held <= '0;
      issuing   <= 1'b0;
      rd_vld    <= 1'b0;
    end else begin
      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && (command == CMD_DECODE)) begin
            acc       <= {acc[ACC_W-2:0], code_bit};
            hold_mask <= {hold_mask[CMP_W-2:0], 1'b1};
            bits_held <= bits_held + 1'b1;
            last_bit  <= message_end;
            issue_idx <= '0;
            issuing   <= 1'b1;
            rd_vld    <= 1'b0;
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          // Address side: one table entry per cycle, lowest symbol first.
          if (issuing) begin
            issue_idx <= issue_idx + 1'b1;
          end
          rd_sym <= issue_idx;
          rd_ok  <= entry_valid[issue_idx];
          rd_end <= (issue_idx == LAST_IDX);
          // Compare side: the first hit stops the scan, which keeps the lowest
          // matching symbol.
          if (hit) begin
            res_symbol <= sym_wide[SYM_W-1:0];
            res_status <= ST_SYMBOL;
            acc        <= '0;
            hold_mask  <= '0;
            bits_held  <= '0;
            issuing    <= 1'b0;
            rd_vld     <= 1'b0;
            state      <= S_EMIT;
          end else begin
            // The read of the last entry is registered ahead of its compare, so the read
            // side drains on its own when the scan ends.
            rd_vld <= issuing;
            if (issuing && (issue_idx == LAST_IDX)) begin
              issuing <= 1'b0;
            end
            if (rd_vld && rd_end) begin
              if (bits_held >= BH_W'(MAX_CODE_LEN)) begin
                res_symbol <= '0;
                res_status <= ST_OVERFLOW;
                acc        <= '0;
                hold_mask  <= '0;
                bits_held  <= '0;
                state      <= S_EMIT;
              end else if (last_bit) begin
                res_symbol <= '0;
                res_status <= ST_LEFTOVER;
                acc        <= '0;
                hold_mask  <= '0;
                bits_held  <= '0;
                state      <= S_EMIT;
              end else begin
                state <= S_IDLE;
              end
            end
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            symbol <= res_symbol;
            status <= res_status;
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/hbd_checker.sv =====
module hbd_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       command,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [hbd_pkg::SYM_W-1:0]  symbol,
  input logic [hbd_pkg::STAT_W-1:0] status
);
  import hbd_pkg::*;

  // A stalled result word holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(symbol) && $stable(status))
    else $error("result word changed or dropped while stalled");

  // Overflow and leftover words carry a zero symbol, and no unused status appears.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_SYMBOL) ||
                  ((status == ST_OVERFLOW || status == ST_LEFTOVER) && symbol == '0))
    else $error("bad status code or nonzero symbol on a non-symbol result");

  // A table load never produces a result word.
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && command == CMD_LOAD && !out_valid |=> !out_valid)
    else $error("result word appeared after a table load");

  // A decode word starts a table scan, during which no input is taken.
  a_scan_interlock: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && command == CMD_DECODE |=> !in_ready)
    else $error("input taken while a table scan runs");

endmodule

bind huffman_bit_decoder hbd_checker u_hbd_checker (.*);

// ===== tb/hbd_result_checker.sv =====
`timescale 1ns / 1ps

module hbd_result_checker #(
  parameter int SYMBOL_COUNT = hbd_pkg::SYMBOL_COUNT_DEF,
  parameter int MAX_CODE_LEN = hbd_pkg::MAX_CODE_LEN_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic                       command,
  input  logic [hbd_pkg::SYM_W-1:0]  entry_symbol,
  input  logic [hbd_pkg::CODE_W-1:0] entry_code,
  input  logic [hbd_pkg::LEN_W-1:0]  entry_length,
  input  logic                       code_bit,
  input  logic                       message_end,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [hbd_pkg::SYM_W-1:0]  symbol,
  input  logic [hbd_pkg::STAT_W-1:0] status,
  output int                         mismatch_total,
  output int                         waiting
);
  import hbd_pkg::*;

  typedef struct packed {
    logic [SYM_W-1:0]  sym;
    logic [STAT_W-1:0] stat;
  } decode_result_t;

  logic [CODE_W-1:0] code_table [SYMBOL_COUNT];
  logic [LEN_W-1:0]  length_table [SYMBOL_COUNT];
  logic [63:0]       accum;
  int                accum_count;
  decode_result_t    due_results [$];

  // Appends one word to the list of words still due from the block.
  function automatic void queue_word(input logic [SYM_W-1:0] sym, input logic [STAT_W-1:0] stat);
    decode_result_t r;
    r.sym  = sym;
    r.stat = stat;
    due_results.insert(due_results.size(), r);
  endfunction

  // Shifts one stream bit in and queues the word it should produce, if any.
  function automatic void shift_in_bit(input logic b, input logic last);
    logic [63:0] mask;
    int          s;
    bit          hit;
    accum = {accum[62:0], b};
    accum_count++;
    hit = 1'b0;
    for (s = 0; s < SYMBOL_COUNT; s++) begin
      mask = (64'd1 << length_table[s]) - 64'd1;
      if (!hit && length_table[s] != 0 && length_table[s] == accum_count &&
          (({32'd0, code_table[s]} ^ accum) & mask) == 64'd0) begin
        queue_word(SYM_W'(s), ST_SYMBOL);
        hit = 1'b1;
      end
    end
    if (!hit && accum_count >= MAX_CODE_LEN)
      queue_word('0, ST_OVERFLOW);
    else if (!hit && last)
      queue_word('0, ST_LEFTOVER);
    if (hit || accum_count >= MAX_CODE_LEN || last) begin
      accum = '0;
      accum_count = 0;
    end
  endfunction

  always @(posedge clk) begin
    decode_result_t want;
    if (rst) begin
      for (int s = 0; s < SYMBOL_COUNT; s++) length_table[s] = '0;
      accum = '0;
      accum_count = 0;
      due_results.delete();
      mismatch_total = 0;
    end else begin
      if (in_valid && in_ready) begin
        if (command == CMD_LOAD) begin
          if (entry_symbol < SYMBOL_COUNT) begin
            code_table[entry_symbol] = entry_code;
            length_table[entry_symbol] = entry_length;
          end
        end else begin
          shift_in_bit(code_bit, message_end);
        end
      end
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          if (mismatch_total < 10)
            $display("checker: unexpected word symbol=%0d status=%0d at %0t",
                     symbol, status, $realtime);
          mismatch_total++;
        end else begin
          want = due_results.pop_front();
          if (symbol !== want.sym || status !== want.stat) begin
            if (mismatch_total < 10)
              $display("checker: mismatch symbol exp %0d got %0d, status exp %0d got %0d at %0t",
                       want.sym, symbol, want.stat, status, $realtime);
            mismatch_total++;
          end
        end
      end
    end
    waiting = due_results.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import hbd_pkg::*;

  // Clock, reset and the two stream channels. Every block input starts at a
  // known value so nothing floats before the first clock edge.
  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              command = CMD_LOAD;
  logic [SYM_W-1:0]  entry_symbol = '0;
  logic [CODE_W-1:0] entry_code = '0;
  logic [LEN_W-1:0]  entry_length = '0;
  logic              code_bit = 1'b0;
  logic              message_end = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [SYM_W-1:0]  symbol;
  logic [STAT_W-1:0] status;

  int mismatch_total;
  int waiting;

  // Flow control knobs. The idle and stall figures are chances out of one
  // hundred per cycle; hold_request asks the receiver for one long hold-off.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_request = 0;
  int words_sent = 0;

  // The code tree of the current table. Leaves come from splitting nodes;
  // the table lists the leaves that were given a symbol, clean of any
  // filler bits above the code length.
  logic [CODE_W-1:0] leaf_code [64];
  int                leaf_len [64];
  int                leaf_total;
  logic [CODE_W-1:0] tbl_code [64];
  int                tbl_len [64];
  logic [SYM_W-1:0]  tbl_sym [64];
  int                tbl_total = 0;
  bit                sym_used [128];

  huffman_bit_decoder dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .entry_symbol(entry_symbol), .entry_code(entry_code),
    .entry_length(entry_length), .code_bit(code_bit), .message_end(message_end),
    .out_valid(out_valid), .out_ready(out_ready),
    .symbol(symbol), .status(status)
  );

  hbd_result_checker u_result_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .entry_symbol(entry_symbol), .entry_code(entry_code),
    .entry_length(entry_length), .code_bit(code_bit), .message_end(message_end),
    .out_valid(out_valid), .out_ready(out_ready),
    .symbol(symbol), .status(status),
    .mismatch_total(mismatch_total), .waiting(waiting)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  // A hard stop in case the block hangs; a correct run, even with the longest
  // stalls, ends before it.
  initial begin
    #4_000_000;
    $display("tb: errors");
    $finish;
  end

  // The receiver. A long hold-off, once asked for, is counted down here in
  // cycles; otherwise ready drops at random at the current stall rate.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Offers one input word and returns at the edge where it is taken. Idle
  // cycles go in front of the word, so valid never drops once raised.
  task automatic send_word(input logic cmd, input logic [SYM_W-1:0] sym,
                           input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len,
                           input logic b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    entry_symbol <= sym;
    entry_code <= code;
    entry_length <= len;
    code_bit <= b;
    message_end <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  // On a load word the stream fields are don't-care, so they carry noise.
  task automatic load_entry(input logic [SYM_W-1:0] sym, input logic [CODE_W-1:0] code,
                            input logic [LEN_W-1:0] len);
    send_word(CMD_LOAD, sym, code, len, 1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  // Likewise the table fields are don't-care on a decode word.
  task automatic put_bit(input logic b, input logic last);
    send_word(CMD_DECODE, SYM_W'($urandom_range(127)), $urandom,
              LEN_W'($urandom_range(32)), b, last);
  endtask

  // Half the time the stored code gets random filler above its length,
  // which the block must ignore when it compares.
  function automatic logic [CODE_W-1:0] with_filler(input logic [CODE_W-1:0] code, input int len);
    return $urandom_range(1) ? (code | ($urandom << len)) : code;
  endfunction

  // Clears the old table, grows a random prefix-free code tree and loads it.
  // Most trees are small and shallow; about one in ten is a long chain whose
  // deepest codes are 23 to 32 bits long. Some leaves stay without a symbol,
  // which leaves holes in the code space for overflow and leftover cases.
  task automatic build_table();
    int               want, pick, i;
    bit               deep;
    logic [SYM_W-1:0] sym;
    for (i = 0; i < tbl_total; i++) begin
      load_entry(tbl_sym[i], $urandom, '0);
      sym_used[tbl_sym[i]] = 1'b0;
    end
    deep = ($urandom_range(9) == 0);
    want = deep ? $urandom_range(24, 33) : $urandom_range(2, 16);
    leaf_total = 1;
    leaf_code[0] = '0;
    leaf_len[0] = 0;
    while (leaf_total < want) begin
      pick = deep ? leaf_total - 1 : $urandom_range(leaf_total - 1);
      if (leaf_len[pick] < 32) begin
        leaf_code[leaf_total] = (leaf_code[pick] << 1) | 1'b1;
        leaf_len[leaf_total] = leaf_len[pick] + 1;
        leaf_code[pick] = leaf_code[pick] << 1;
        leaf_len[pick] = leaf_len[pick] + 1;
        leaf_total++;
      end
    end
    tbl_total = 0;
    for (i = 0; i < leaf_total; i++) begin
      if (leaf_total > 2 && $urandom_range(5) == 0) continue;
      do sym = SYM_W'($urandom_range(127)); while (sym_used[sym]);
      sym_used[sym] = 1'b1;
      tbl_code[tbl_total] = leaf_code[i];
      tbl_len[tbl_total] = leaf_len[i];
      tbl_sym[tbl_total] = sym;
      tbl_total++;
      load_entry(sym, with_filler(leaf_code[i], leaf_len[i]), LEN_W'(leaf_len[i]));
    end
  endtask

  // Sends the codes of a few random table symbols, most significant bit
  // first, marking the final bit as the message end. Now and then a table
  // entry is rewritten mid-code, which must not disturb the held bits. A
  // broken message stops inside its last code, leaving bits over.
  task automatic send_message();
    int parts, n, j, e, e2, stop_bit;
    bit broken;
    parts = $urandom_range(1, 6);
    broken = ($urandom_range(6) == 0);
    for (n = 0; n < parts; n++) begin
      e = $urandom_range(tbl_total - 1);
      stop_bit = 0;
      if (broken && n == parts - 1 && tbl_len[e] > 1)
        stop_bit = $urandom_range(1, tbl_len[e] - 1);
      for (j = tbl_len[e] - 1; j >= stop_bit; j--) begin
        if ($urandom_range(24) == 0) begin
          e2 = $urandom_range(tbl_total - 1);
          load_entry(tbl_sym[e2], with_filler(tbl_code[e2], tbl_len[e2]),
                     LEN_W'(tbl_len[e2]));
        end
        put_bit(tbl_code[e][j], n == parts - 1 && j == stop_bit);
      end
    end
  endtask

  // A run of random bits, ending a message on its last bit half the time.
  // Long runs through holes in the table hit the code length limit.
  task automatic send_noise();
    int count, i;
    bit ends;
    count = $urandom_range(1, 40);
    ends = 1'($urandom_range(1));
    for (i = 0; i < count; i++)
      put_bit(1'($urandom_range(1)), ends && i == count - 1);
  endtask

  initial begin
    int phase, stop_at, i, r;
    do @(posedge clk); while (rst);

    // Empty table: a lone final bit can only be reported as leftover.
    put_bit(1'b1, 1'b1);
    // A full-width code of all ones, and code "0" with its upper bits set.
    load_entry(7'd127, 32'hFFFF_FFFF, 6'd32);
    load_entry(7'd1, 32'hFFFF_FFFE, 6'd1);
    // Two symbols share code "10"; the lower one, symbol 3, must win.
    load_entry(7'd5, 32'h0000_0002, 6'd2);
    load_entry(7'd3, 32'hABCD_0002, 6'd2);
    // A zero length marks a symbol absent.
    load_entry(7'd100, 32'h0000_0000, 6'd0);
    put_bit(1'b0, 1'b0);
    put_bit(1'b1, 1'b0);
    put_bit(1'b0, 1'b0);
    // With symbol 3 gone, "10" decodes to 5. A load between the two bits
    // must leave the held bit in place.
    load_entry(7'd3, 32'h0000_0000, 6'd0);
    put_bit(1'b1, 1'b0);
    load_entry(7'd64, 32'h5555_5555, 6'd0);
    put_bit(1'b0, 1'b0);
    // A match on the final bit gives the symbol and no leftover report.
    put_bit(1'b0, 1'b1);
    // "11" matches nothing and is reported as leftover at the message end.
    put_bit(1'b1, 1'b0);
    put_bit(1'b1, 1'b1);
    load_entry(7'd127, $urandom, 6'd0);
    load_entry(7'd1, $urandom, 6'd0);
    load_entry(7'd5, $urandom, 6'd0);
    // Empty table again: 32 bits with the end on the last one must give the
    // overflow report only.
    for (i = 0; i < 32; i++) put_bit(1'($urandom_range(1)), i == 31);

    // Four flow control phases of about equal size. The first one also has
    // the receiver hold off long enough that the block backs up and stops
    // taking input while the sender keeps offering.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          hold_request = 1000;
        end
        1: begin
          send_idle_pct = 70;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 70;
        end
        default: begin
          send_idle_pct = 28;
          recv_stall_pct = 28;
        end
      endcase
      stop_at = 1150 * (phase + 1) / 4;
      while (words_sent < stop_at) begin
        r = $urandom_range(99);
        if (r < 8 || tbl_total == 0) build_table();
        else if (r < 18) send_noise();
        else send_message();
      end
    end
    in_valid <= 1'b0;

    // Drain: every expected word must arrive, then allow one full table
    // scan for anything unexpected still on its way. The first edge lets
    // the checker count the last word taken.
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (SYMBOL_COUNT_DEF + 8) @(posedge clk);
    if (mismatch_total == 0 && waiting == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule
